>>> hdl/tvf_pkg.sv
// tvf_pkg: shared constants, character codes and types for the text view filter.
// No dependencies.
package tvf_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int MIN_WIDTH  = 6;
  localparam int BODY_MAX   = 4;
  localparam int MAX_RUN    = NUM_DIGITS + 1 + BODY_MAX;
  localparam int POS_W      = $clog2(MAX_RUN + 1);
  localparam int DIG_W      = $clog2(NUM_DIGITS);
  localparam int BODY_W     = $clog2(BODY_MAX);
  localparam int BLEN_W     = $clog2(BODY_MAX + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_LINES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NONBLANK_ONLY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_LINE_ENDS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd5;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_M         = 8'h4D;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;
  localparam logic [7:0] CARET_OFFSET = 8'h40;

  typedef struct packed {
    logic number_lines;
    logic number_nonblank_only;
    logic mark_line_ends;
    logic squeeze_blank_lines;
    logic show_nonprinting;
    logic show_tabs;
  } cfg_t;

  // one input byte's output run: optional number prefix, then body bytes
  typedef struct packed {
    logic                             num_on;
    logic [NUM_DIGITS-1:0][3:0]       digits;
    logic [DIG_W-1:0]                 top;
    logic [POS_W-1:0]                 num_len;
    logic [POS_W-1:0]                 body_start;
    logic [POS_W-1:0]                 total_len;
    logic [BODY_MAX-1:0][7:0]         body;
  } run_t;

endpackage

>>> hdl/tvf_line_state.sv
// tvf_line_state: line counter, line/blank tracking, and run decode per input byte.
// Depends on tvf_pkg.
module tvf_line_state (
  input  logic               clk,
  input  logic               rst,
  input  tvf_pkg::cfg_t      cfg,
  input  logic [7:0]         in_byte,
  input  logic               accept,
  output tvf_pkg::run_t      run,
  output logic               run_empty
);

  logic [tvf_pkg::NUM_DIGITS-1:0][3:0] line_number;
  logic [tvf_pkg::NUM_DIGITS-1:0][3:0] line_number_next;
  logic inside_line;
  logic previous_blank;

  logic is_nl;
  logic num_on;
  logic [tvf_pkg::DIG_W-1:0] top;
  logic [tvf_pkg::POS_W-1:0] width;
  logic [tvf_pkg::POS_W-1:0] num_len;
  logic [tvf_pkg::BODY_MAX-1:0][7:0] body;
  logic [tvf_pkg::BLEN_W-1:0] blen;
  logic [tvf_pkg::BLEN_W-1:0] tail_len;
  logic [7:0] lo;
  logic [7:0] tail0;
  logic [7:0] tail1;
  logic all_nine;
  logic low_nine;

  assign is_nl = (in_byte == tvf_pkg::CH_NL);
  assign run_empty = is_nl && !inside_line && cfg.squeeze_blank_lines && previous_blank;
  assign num_on = is_nl ? (!inside_line && cfg.number_lines && !cfg.number_nonblank_only)
                        : (cfg.number_lines && !inside_line);

  always_comb begin
    top = '0;
    for (int i = 0; i < tvf_pkg::NUM_DIGITS; i++) begin
      if (line_number[i] != 4'd0) top = i[tvf_pkg::DIG_W-1:0];
    end
  end

  assign width   = tvf_pkg::POS_W'(top) + tvf_pkg::POS_W'(1);
  assign num_len = (width < tvf_pkg::POS_W'(tvf_pkg::MIN_WIDTH))
                   ? tvf_pkg::POS_W'(tvf_pkg::MIN_WIDTH) : width;

  // body bytes
  always_comb begin
    lo = {1'b0, in_byte[6:0]};
    if (lo < tvf_pkg::CTRL_LIMIT) begin
      tail0 = tvf_pkg::CH_CARET;
      tail1 = lo + tvf_pkg::CARET_OFFSET;
      tail_len = tvf_pkg::BLEN_W'(2);
    end else if (lo == tvf_pkg::CH_DEL) begin
      tail0 = tvf_pkg::CH_CARET;
      tail1 = tvf_pkg::CH_QMARK;
      tail_len = tvf_pkg::BLEN_W'(2);
    end else begin
      tail0 = lo;
      tail1 = 8'h00;
      tail_len = tvf_pkg::BLEN_W'(1);
    end
    body = '0;
    blen = tvf_pkg::BLEN_W'(1);
    if (is_nl) begin
      if (cfg.mark_line_ends) begin
        body[0] = tvf_pkg::CH_DOLLAR;
        body[1] = tvf_pkg::CH_NL;
        blen = tvf_pkg::BLEN_W'(2);
      end else begin
        body[0] = tvf_pkg::CH_NL;
      end
    end else if (cfg.show_nonprinting && (cfg.show_tabs || in_byte != tvf_pkg::CH_TAB)) begin
      if (in_byte[7]) begin
        body[0] = tvf_pkg::CH_M;
        body[1] = tvf_pkg::CH_DASH;
        body[2] = tail0;
        body[3] = tail1;
        blen = tvf_pkg::BLEN_W'(2) + tail_len;
      end else begin
        body[0] = tail0;
        body[1] = tail1;
        blen = tail_len;
      end
    end else begin
      body[0] = in_byte;
    end
  end

  always_comb begin
    run.num_on     = num_on;
    run.digits     = line_number;
    run.top        = top;
    run.num_len    = num_len;
    run.body_start = num_on ? (num_len + tvf_pkg::POS_W'(1)) : '0;
    run.total_len  = run.body_start + tvf_pkg::POS_W'(blen);
    run.body       = body;
  end

  // saturating BCD increment
  always_comb begin
    all_nine = 1'b1;
    for (int i = 0; i < tvf_pkg::NUM_DIGITS; i++) begin
      if (line_number[i] != 4'd9) all_nine = 1'b0;
    end
    low_nine = 1'b1;
    line_number_next = line_number;
    for (int i = 0; i < tvf_pkg::NUM_DIGITS; i++) begin
      if (low_nine && !all_nine) begin
        line_number_next[i] = (line_number[i] >= 4'd9) ? 4'd0 : line_number[i] + 4'd1;
      end
      low_nine = low_nine && (line_number[i] >= 4'd9);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_number    <= {{(tvf_pkg::NUM_DIGITS-1){4'd0}}, 4'd1};
      inside_line    <= 1'b0;
      previous_blank <= 1'b0;
    end else if (accept && !run_empty) begin
      if (num_on) line_number <= line_number_next;
      inside_line <= !is_nl;
      if (!is_nl) begin
        previous_blank <= 1'b0;
      end else if (!inside_line) begin
        previous_blank <= 1'b1;
      end
    end
  end

endmodule

>>> hdl/tvf_emitter.sv
// tvf_emitter: run register, byte position sequencer and output register.
// Depends on tvf_pkg.
module tvf_emitter (
  input  logic            clk,
  input  logic            rst,
  input  tvf_pkg::run_t   run,
  input  logic            run_empty,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            accept,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  tvf_pkg::run_t desc;
  logic desc_valid;
  logic [tvf_pkg::POS_W-1:0] pos;

  logic out_free;
  logic step;
  logic last;
  logic done;
  logic [7:0] cur_byte;
  logic [tvf_pkg::POS_W-1:0] dig_idx;
  logic [tvf_pkg::POS_W-1:0] body_idx;

  assign out_free = !out_valid || !out_stall;
  assign step     = desc_valid && out_free;
  assign last     = (pos == desc.total_len - tvf_pkg::POS_W'(1));
  assign done     = step && last;
  assign in_stall = desc_valid && !done;
  assign accept   = in_valid && !in_stall;
  assign busy     = desc_valid;

  assign dig_idx  = desc.num_len - tvf_pkg::POS_W'(1) - pos;
  assign body_idx = pos - desc.body_start;

  always_comb begin
    if (desc.num_on && pos < desc.num_len) begin
      if (dig_idx > tvf_pkg::POS_W'(desc.top)) begin
        cur_byte = tvf_pkg::CH_SPACE;
      end else begin
        cur_byte = tvf_pkg::CH_ZERO | {4'h0, desc.digits[dig_idx[tvf_pkg::DIG_W-1:0]]};
      end
    end else if (desc.num_on && pos < desc.body_start) begin
      cur_byte = tvf_pkg::CH_TAB;
    end else begin
      cur_byte = desc.body[body_idx[tvf_pkg::BODY_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      pos        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && !run_empty) begin
        desc_valid <= 1'b1;
        pos        <= '0;
      end else if (done) begin
        desc_valid <= 1'b0;
      end else if (step) begin
        pos <= pos + tvf_pkg::POS_W'(1);
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !run_empty) desc <= run;
    if (step) begin
      out_byte    <= cur_byte;
      last_of_run <= last;
    end
  end

endmodule

>>> hdl/text_view_filter.sv
// text_view_filter: renders a text byte stream in display form with optional numbering.
// The first output byte of a request passes the run register, then the output register.
// Throughput: one output byte per cycle while out_stall is low; a multi-byte request keeps
// the single output byte sequencer to its last byte, so input stalls (none for ordinary text).
// Reset: synchronous rst clears the settings, sets the line counter to one, empties the pipe.
// Depends on tvf_pkg, tvf_line_state, tvf_emitter.
module text_view_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [tvf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         last_of_run
);

  tvf_pkg::cfg_t cfg;
  tvf_pkg::run_t run;
  logic run_empty;
  logic accept;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tvf_pkg::REG_NUMBER_LINES:   cfg.number_lines         <= cfg_data;
        tvf_pkg::REG_NONBLANK_ONLY:  cfg.number_nonblank_only <= cfg_data;
        tvf_pkg::REG_MARK_LINE_ENDS: cfg.mark_line_ends       <= cfg_data;
        tvf_pkg::REG_SQUEEZE_BLANK:  cfg.squeeze_blank_lines  <= cfg_data;
        tvf_pkg::REG_SHOW_NONPRINT:  cfg.show_nonprinting     <= cfg_data;
        tvf_pkg::REG_SHOW_TABS:      cfg.show_tabs            <= cfg_data;
        default: ;
      endcase
    end
  end

  tvf_line_state u_line_state (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_byte   (in_byte),
    .accept    (accept),
    .run       (run),
    .run_empty (run_empty)
  );

  tvf_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .run         (run),
    .run_empty   (run_empty),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .accept      (accept),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  // a run's bytes follow one another without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside an output run");

  // a pending run always reaches the output register when it is free
  a_busy_feeds_out: assert property (@(posedge clk) disable iff (rst)
    busy && !out_stall |=> out_valid)
    else $error("pending run did not produce a byte");

  // input held only while a run is pending
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> busy)
    else $error("input stalled with no pending run");

endmodule

>>> verif/text_view_filter_checker.sv
// text_view_filter_checker: watches the settings port and both request channels, renders
// each accepted input byte into the bytes it should display, and compares the output stream.
// Depends on tvf_pkg.
`timescale 1ns / 1ps
module text_view_filter_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tvf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_byte,
  input  logic                          last_of_run,
  output int                            errors,
  output int                            pending
);

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } shown_t;

  shown_t                              shown_q[$];
  tvf_pkg::cfg_t                       mode;
  logic [tvf_pkg::NUM_DIGITS-1:0][3:0] line_no;
  logic                                in_line;
  logic                                blank_before;
  int                                  miss = 0;

  assign errors = miss;

  function automatic void show(input logic [7:0] ch);
    shown_t s;
    s.ch = ch;
    s.last = 1'b0;
    shown_q.push_back(s);
  endfunction

  // right-aligned decimal, at least MIN_WIDTH wide, then tab; counter sticks at all nines
  function automatic void show_line_number();
    int   top;
    int   width;
    logic full;
    logic carry;
    top = 0;
    full = 1'b1;
    for (int i = 0; i < tvf_pkg::NUM_DIGITS; i++) begin
      if (line_no[i] != 4'd0) top = i;
      if (line_no[i] != 4'd9) full = 1'b0;
    end
    width = (top + 1 < tvf_pkg::MIN_WIDTH) ? tvf_pkg::MIN_WIDTH : top + 1;
    for (int i = width - 1; i >= 0; i--) begin
      if (i > top) show(tvf_pkg::CH_SPACE);
      else show(tvf_pkg::CH_ZERO + {4'd0, line_no[i]});
    end
    show(tvf_pkg::CH_TAB);
    if (!full) begin
      carry = 1'b1;
      for (int i = 0; i < tvf_pkg::NUM_DIGITS; i++) begin
        if (carry) begin
          if (line_no[i] >= 4'd9) begin
            line_no[i] = 4'd0;
          end else begin
            line_no[i] = line_no[i] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endfunction

  function automatic void render_byte(input logic [7:0] c);
    int         base;
    logic [7:0] b;
    shown_t     tail;
    base = shown_q.size();
    b = c;
    if (c == tvf_pkg::CH_NL) begin
      if (!in_line) begin
        if (mode.squeeze_blank_lines && blank_before) return;
        blank_before = 1'b1;
        if (mode.number_lines && !mode.number_nonblank_only) show_line_number();
      end
      if (mode.mark_line_ends) show(tvf_pkg::CH_DOLLAR);
      show(tvf_pkg::CH_NL);
      in_line = 1'b0;
    end else begin
      if (mode.number_lines && !in_line) show_line_number();
      in_line = 1'b1;
      if (mode.show_nonprinting && (mode.show_tabs || c != tvf_pkg::CH_TAB)) begin
        if (b[7]) begin
          show(tvf_pkg::CH_M);
          show(tvf_pkg::CH_DASH);
          b[7] = 1'b0;
        end
        if (b < tvf_pkg::CTRL_LIMIT) begin
          show(tvf_pkg::CH_CARET);
          show(b + tvf_pkg::CARET_OFFSET);
        end else if (b == tvf_pkg::CH_DEL) begin
          show(tvf_pkg::CH_CARET);
          show(tvf_pkg::CH_QMARK);
        end else begin
          show(b);
        end
      end else begin
        show(c);
      end
      blank_before = 1'b0;
    end
    if (shown_q.size() > base) begin
      tail = shown_q.pop_back();
      tail.last = 1'b1;
      shown_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : watch
    shown_t want;
    if (rst) begin
      mode = '0;
      line_no = '0;
      line_no[0] = 4'd1;
      in_line = 1'b0;
      blank_before = 1'b0;
      shown_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tvf_pkg::REG_NUMBER_LINES:   mode.number_lines = cfg_data;
          tvf_pkg::REG_NONBLANK_ONLY:  mode.number_nonblank_only = cfg_data;
          tvf_pkg::REG_MARK_LINE_ENDS: mode.mark_line_ends = cfg_data;
          tvf_pkg::REG_SQUEEZE_BLANK:  mode.squeeze_blank_lines = cfg_data;
          tvf_pkg::REG_SHOW_NONPRINT:  mode.show_nonprinting = cfg_data;
          tvf_pkg::REG_SHOW_TABS:      mode.show_tabs = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) render_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (shown_q.size() == 0) begin
          if (miss < 10)
            $display("unexpected output: byte %02h last %0d", out_byte, last_of_run);
          miss++;
        end else begin
          want = shown_q.pop_front();
          if (want.ch !== out_byte || want.last !== last_of_run) begin
            if (miss < 10)
              $display("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                       want.ch, want.last, out_byte, last_of_run);
            miss++;
          end
        end
      end
    end
    pending <= shown_q.size();
  end

endmodule

>>> verif/testbench.sv
// testbench: drives settings and text bytes into text_view_filter with random idling and a
// long output hold-off; text_view_filter_checker predicts and compares. Depends on tvf_pkg.
`timescale 1ns / 1ps
module testbench;

  localparam logic [tvf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tvf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int STALL_PCT   = 37;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 6;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 28;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [tvf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                          cfg_data = 1'b0;
  logic                          in_valid = 1'b0;
  logic [7:0]                    in_byte = '0;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [7:0]                    out_byte;
  logic                          last_of_run;
  int                            errors;
  int                            pending;
  int                            quiet_cycles = 0;
  bit                            calm = 1'b0;
  bit                            hold_req = 1'b0;
  bit                            hold_done = 1'b0;

  text_view_filter i_dut (.*);
  text_view_filter_checker i_checker (.*);

  always #5 clk = ~clk;

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("** text_view_filter: FAILED **");
      $finish;
    end
  end

  task automatic offer(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_byte <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [tvf_pkg::CFG_IDX_W-1:0] idx, input logic val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input tvf_pkg::cfg_t s, input bit spare);
    put_reg(tvf_pkg::REG_NUMBER_LINES, s.number_lines);
    put_reg(tvf_pkg::REG_NONBLANK_ONLY, s.number_nonblank_only);
    put_reg(tvf_pkg::REG_MARK_LINE_ENDS, s.mark_line_ends);
    put_reg(tvf_pkg::REG_SQUEEZE_BLANK, s.squeeze_blank_lines);
    put_reg(tvf_pkg::REG_SHOW_NONPRINT, s.show_nonprinting);
    put_reg(tvf_pkg::REG_SHOW_TABS, s.show_tabs);
    if (spare) begin
      put_reg(REG_SPARE_LO, 1'b1);
      put_reg(REG_SPARE_HI, 1'b1);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return tvf_pkg::CH_NL;
    if (r < 18) return tvf_pkg::CH_TAB;
    if (r < 60) return 8'($urandom_range(32, 126));
    if (r < 72) return 8'($urandom_range(0, 31));
    if (r < 75) return tvf_pkg::CH_DEL;
    if (r < 90) return 8'($urandom_range(128, 255));
    return 8'($urandom);
  endfunction

  initial begin
    tvf_pkg::cfg_t s;
    logic [7:0]    seq[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // blank-line squeeze, caret and M- forms, byte extremes
    s = '1;
    s.number_nonblank_only = 1'b0;
    apply_settings(s, 1'b1);
    seq = '{tvf_pkg::CH_NL, tvf_pkg::CH_NL, tvf_pkg::CH_NL, 8'h00, tvf_pkg::CH_TAB, 8'h1F,
            tvf_pkg::CH_DEL, 8'h80, 8'h89, 8'h9F, 8'hFF, 8'hA0, 8'h7E, tvf_pkg::CH_SPACE,
            tvf_pkg::CH_NL};
    foreach (seq[i]) offer(seq[i]);
    drain();

    // tabs flag alone, nonblank-only numbering
    s = '0;
    s.number_lines = 1'b1;
    s.number_nonblank_only = 1'b1;
    s.show_tabs = 1'b1;
    apply_settings(s, 1'b0);
    seq = '{tvf_pkg::CH_TAB, 8'hFF, 8'h00, tvf_pkg::CH_NL, tvf_pkg::CH_NL, 8'h41,
            tvf_pkg::CH_NL};
    foreach (seq[i]) offer(seq[i]);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) s = '0;
      else if (phase == 1) s = '1;
      else s = tvf_pkg::cfg_t'(6'($urandom));
      apply_settings(s, phase == 2);
      calm = (phase == 4 || phase == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == 5) hold_req = 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(2, 4)) offer(tvf_pkg::CH_NL);
        else offer(pick_text_byte());
      end
      drain();
    end

    if (errors == 0 && pending == 0) $display("** text_view_filter: PASSED **");
    else $display("** text_view_filter: FAILED **");
    $finish;
  end

endmodule
